/* rtl/core/srr_pkg.sv */
// Package for the selective-repeat receiver core.
// Holds field widths, item structs, result kind codes, FSM state and RAM control types.
// No dependencies.
`default_nettype none

package srr_pkg;

    localparam int SEQ_BITS     = 4;
    localparam int PAYLOAD_BITS = 32;
    localparam int WINDOW_DEF   = 8;
    localparam int SEQ_SPACE    = 1 << SEQ_BITS;
    localparam int HALF_SPACE   = 1 << (SEQ_BITS - 1);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic [SEQ_BITS-1:0]     seq_num;
        logic [PAYLOAD_BITS-1:0] payload_word;
        logic                    checksum_ok;
    } in_item_t;

    typedef struct packed {
        logic                    result_kind;
        logic [PAYLOAD_BITS-1:0] delivered_data;
        logic [SEQ_BITS-1:0]     ack_seq;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_ACK
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/srr_slot_ram.sv */
// Slot payload memory: one write port, one read port, registered read data.
// Depends on srr_pkg for the payload width, the default depth and the ram_ctl_t struct.
`default_nettype none

module srr_slot_ram #(
    parameter int DEPTH  = srr_pkg::WINDOW_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                                clk,
    input  wire srr_pkg::ram_ctl_t             ctl,
    input  wire  [ADDR_W-1:0]                  wr_addr,
    input  wire  [srr_pkg::PAYLOAD_BITS-1:0]   wr_data,
    input  wire  [ADDR_W-1:0]                  rd_addr,
    output logic [srr_pkg::PAYLOAD_BITS-1:0]   rd_data
);

    logic [srr_pkg::PAYLOAD_BITS-1:0] mem [DEPTH];
    logic [srr_pkg::PAYLOAD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/srr_ctrl.sv */
// Receive control: window base, slot valid bits, sequencing FSM and result selection.
// Depends on srr_pkg; drives srr_slot_ram through a ram_ctl_t struct.
`default_nettype none

module srr_ctrl #(
    parameter int WINDOW = srr_pkg::WINDOW_DEF,
    parameter int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire srr_pkg::in_item_t             in_item,
    input  wire                                out_free,
    output logic                               out_load,
    output srr_pkg::out_item_t                 out_item,
    output srr_pkg::ram_ctl_t                  ram_ctl,
    output logic [SLOT_W-1:0]                  wr_addr,
    output logic [SLOT_W-1:0]                  rd_addr,
    input  wire  [srr_pkg::PAYLOAD_BITS-1:0]   rd_data
);

    localparam int EFF_WIN = (WINDOW < srr_pkg::HALF_SPACE) ? WINDOW : srr_pkg::HALF_SPACE;
    localparam int SB      = srr_pkg::SEQ_BITS;

    logic [SLOT_W-1:0] slot_lut [srr_pkg::SEQ_SPACE];

    for (genvar i = 0; i < srr_pkg::SEQ_SPACE; i++)
    begin : g_lut
        assign slot_lut[i] = SLOT_W'(i % WINDOW);
    end

    srr_pkg::state_t   state_reg, state_next;
    logic [SB-1:0]     base_reg, base_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [SB-1:0]     seq_reg, seq_next;

    logic              accept;
    logic [SB-1:0]     offset;
    logic              in_win;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] head_slot;
    logic              head_valid;

    assign accept     = in_valid && in_ready;
    assign offset     = in_item.seq_num - base_reg;
    assign in_win     = {1'b0, offset} < (SB + 1)'(EFF_WIN);
    assign in_slot    = slot_lut[in_item.seq_num];
    assign head_slot  = slot_lut[base_reg];
    assign head_valid = valid_reg[head_slot];
    assign wr_addr    = in_slot;
    assign rd_addr    = head_slot;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                if (accept && in_item.checksum_ok)
                begin
                    state_next = srr_pkg::ST_SCAN;
                end
            end
            srr_pkg::ST_SCAN:
            begin
                if (head_valid)
                begin
                    state_next = srr_pkg::ST_FETCH;
                end
                else if (out_free)
                begin
                    state_next = srr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = srr_pkg::ST_ACK;
                end
            end
            srr_pkg::ST_FETCH:
            begin
                if (out_free)
                begin
                    state_next = srr_pkg::ST_SCAN;
                end
            end
            srr_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        ram_ctl.wr_en = 1'b0;
        ram_ctl.rd_en = 1'b0;
        out_load      = 1'b0;
        out_item.result_kind    = srr_pkg::KIND_ACK;
        out_item.delivered_data = '0;
        out_item.ack_seq        = seq_reg;
        out_item.last           = 1'b1;
        case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                ram_ctl.wr_en = in_valid && in_item.checksum_ok && in_win && !valid_reg[in_slot];
            end
            srr_pkg::ST_SCAN:
            begin
                ram_ctl.rd_en = head_valid;
                out_load      = !head_valid && out_free;
            end
            srr_pkg::ST_FETCH:
            begin
                out_load                = out_free;
                out_item.result_kind    = srr_pkg::KIND_DATA;
                out_item.delivered_data = rd_data;
                out_item.ack_seq        = '0;
                out_item.last           = 1'b0;
            end
            srr_pkg::ST_ACK:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        base_next  = base_reg;
        seq_next   = seq_reg;
        if (ram_ctl.wr_en)
        begin
            valid_next[in_slot] = 1'b1;
        end
        if (ram_ctl.rd_en)
        begin
            valid_next[head_slot] = 1'b0;
            base_next             = base_reg + 1'b1;
        end
        if (accept)
        begin
            seq_next = in_item.seq_num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srr_pkg::ST_IDLE;
            base_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

    a_rd_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.rd_en |=> (state_reg == srr_pkg::ST_FETCH))
        else $error("slot read not followed by fetch");

    a_rd_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.rd_en |=> !valid_reg[$past(head_slot)])
        else $error("delivered slot still marked valid");

    a_base_moves_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        !ram_ctl.rd_en |=> $stable(base_reg))
        else $error("window base moved without a delivery");

    a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !in_ready)
        else $error("result loaded while taking an item");

    a_wr_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.wr_en |-> !ram_ctl.rd_en && !valid_reg[in_slot])
        else $error("slot written while occupied or during read");

endmodule

`default_nettype wire

/* rtl/core/selective_repeat_receiver_core.sv */
// Selective-repeat ARQ receiver core: top level with the result output register.
// Depends on srr_pkg, srr_ctrl and srr_slot_ram.
//
// Input channel (in_valid/in_ready/in_item) takes one packet: sequence number,
// payload word and checksum flag. A corrupt packet is dropped with no result.
// A good packet inside the receive window is stored in its slot; then every
// consecutive stored payload from the window base is delivered in order on
// the output channel (out_valid/out_ready/out_item, result_kind data), and
// an ack with the packet's sequence number closes the packet with last set.
// Sequencing: for each delivered payload, ST_SCAN checks the head slot and
// reads the slot RAM, then ST_FETCH loads the registered read data into the
// output register. in_ready is high only between packets; the output
// register lets the next packet be taken while the closing ack waits. When
// out_ready is low the sequencer holds its place.
// Reset clears the window base and all slot valid bits at once; the slot
// payload RAM is not cleared and needs no sweep.
`default_nettype none

module selective_repeat_receiver_core #(
    parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire srr_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire                     out_ready,
    output srr_pkg::out_item_t      out_item
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    srr_pkg::ram_ctl_t                ram_ctl;
    logic [SLOT_W-1:0]                wr_addr;
    logic [SLOT_W-1:0]                rd_addr;
    logic [srr_pkg::PAYLOAD_BITS-1:0] rd_data;
    logic                             out_free;
    logic                             out_load;
    srr_pkg::out_item_t               load_item;

    logic               out_valid_reg, out_valid_next;
    srr_pkg::out_item_t out_item_reg, out_item_next;

    srr_ctrl #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_free (out_free),
        .out_load (out_load),
        .out_item (load_item),
        .ram_ctl  (ram_ctl),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    srr_slot_ram #(
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_data (in_item.payload_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_item_next  = load_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* dv/srr_checker.sv */
// Checker for the selective-repeat receiver core: watches both channels, keeps its own
// receive window, slot store and result queue, and compares every result field by field.
// Depends on srr_pkg.
`default_nettype none

module srr_checker #(
    parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  srr_pkg::in_item_t   in_item,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  srr_pkg::out_item_t  out_item,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EFF_WIN = (WINDOW < srr_pkg::HALF_SPACE) ? WINDOW : srr_pkg::HALF_SPACE;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [srr_pkg::SEQ_BITS-1:0]     rx_base;
    logic [srr_pkg::PAYLOAD_BITS-1:0] slot_word [WINDOW];
    bit                               slot_held [WINDOW];
    srr_pkg::out_item_t               awaited_results [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Buffer the packet if it falls in the window, drain the in-order run, then ack.
    task automatic absorb_packet(input srr_pkg::in_item_t pkt);
        logic [srr_pkg::SEQ_BITS-1:0] offset;
        logic [SLOT_W-1:0]            slot;
        srr_pkg::out_item_t           res;
        if (!pkt.checksum_ok)
            return;
        offset = pkt.seq_num - rx_base;
        if (offset < EFF_WIN)
        begin
            slot = SLOT_W'(pkt.seq_num % WINDOW);
            if (!slot_held[slot])
            begin
                slot_word[slot] = pkt.payload_word;
                slot_held[slot] = 1'b1;
            end
        end
        for (int n = 0; n < WINDOW; n++)
        begin
            slot = SLOT_W'(rx_base % WINDOW);
            if (!slot_held[slot])
                break;
            res                = '0;
            res.result_kind    = srr_pkg::KIND_DATA;
            res.delivered_data = slot_word[slot];
            awaited_results.push_back(res);
            slot_held[slot] = 1'b0;
            rx_base         = rx_base + 1'b1;
        end
        res             = '0;
        res.result_kind = srr_pkg::KIND_ACK;
        res.ack_seq     = pkt.seq_num;
        res.last        = 1'b1;
        awaited_results.push_back(res);
    endtask

    task automatic compare_result(input srr_pkg::out_item_t got);
        srr_pkg::out_item_t want;
        if (awaited_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %h, expected %h",
                                      got.result_kind, want.result_kind));
        if (got.delivered_data !== want.delivered_data)
            report_mismatch($sformatf("delivered_data %h, expected %h",
                                      got.delivered_data, want.delivered_data));
        if (got.ack_seq !== want.ack_seq)
            report_mismatch($sformatf("ack_seq %h, expected %h", got.ack_seq, want.ack_seq));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_base = '0;
            for (int i = 0; i < WINDOW; i++)
                slot_held[SLOT_W'(i)] = 1'b0;
            awaited_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                compare_result(out_item);
            if (in_valid && in_ready)
                absorb_packet(in_item);
        end
        pending_count = awaited_results.size();
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Top of the selective-repeat receiver testbench: clock, reset, packet stimulus and
// receiver back-pressure around the core, with srr_checker doing the comparison.
// Depends on srr_pkg, selective_repeat_receiver_core and srr_checker.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = srr_pkg::WINDOW_DEF;
    localparam int SEQ_W        = srr_pkg::SEQ_BITS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 135;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    srr_pkg::in_item_t  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    srr_pkg::out_item_t out_item;

    int fail_count;
    int pending_count;

    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int good_sent     = 0;

    logic [SEQ_W-1:0] tx_base;

    selective_repeat_receiver_core #(.WINDOW(WINDOW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    srr_checker #(.WINDOW(WINDOW)) checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input srr_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.checksum_ok)
            good_sent++;
        @(negedge clk);
    endtask

    task automatic send_pkt(input logic [SEQ_W-1:0] seq,
                            input logic [srr_pkg::PAYLOAD_BITS-1:0] pay,
                            input logic ok);
        srr_pkg::in_item_t it;
        it.seq_num      = seq;
        it.payload_word = pay;
        it.checksum_ok  = ok;
        send_item(it);
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Up to one window's worth of packets from tx_base in shuffled order, with
    // corrupt copies, duplicates, stale retransmits and packets past the window mixed in.
    task automatic send_burst();
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] tmp;
        int               len;
        int               k;
        len = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, WINDOW);
        order.delete();
        for (int j = 0; j < len; j++)
            order.push_back(SEQ_W'(tx_base + j));
        for (int j = len - 1; j > 0; j--)
        begin
            k        = $urandom_range(j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        if ($urandom_range(9) == 0)
            send_pkt(SEQ_W'(tx_base + WINDOW + $urandom_range(WINDOW - 1)), $urandom, 1'b1);
        if ($urandom_range(14) == 0)
            send_pkt(SEQ_W'($urandom), $urandom, 1'b0);
        for (int j = 0; j < len; j++)
        begin
            if ($urandom_range(9) == 0)
                send_pkt(($urandom_range(1) == 0) ? order[j] : SEQ_W'($urandom),
                         $urandom, 1'b0);
            send_pkt(order[j], $urandom, 1'b1);
            if ($urandom_range(11) == 0)
                send_pkt(order[($urandom_range(j))], $urandom, 1'b1);
        end
        tx_base = SEQ_W'(tx_base + len);
    endtask

    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 53;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // in order, field extremes, corrupt copy before a good one
        send_pkt(4'd0, 32'h0000_0000, 1'b1);
        send_pkt(4'd1, 32'hFFFF_FFFF, 1'b1);
        send_pkt(4'd2, 32'h1234_5678, 1'b0);
        send_pkt(4'd2, 32'hA5A5_A5A5, 1'b1);
        // stale packet below the window, top edge of window, just past it
        send_pkt(4'd0, 32'h5A5A_5A5A, 1'b1);
        send_pkt(4'd10, 32'h0A0A_0A0A, 1'b1);
        send_pkt(4'd11, 32'hDEAD_BEEF, 1'b1);
        // duplicate of a buffered packet keeps the first copy
        send_pkt(4'd5, 32'h5555_0001, 1'b1);
        send_pkt(4'd5, 32'h5555_0002, 1'b1);
        send_pkt(4'd4, 32'h4444_4444, 1'b1);
        send_pkt(4'd3, 32'h3333_3333, 1'b1);
        for (int s = 6; s <= 9; s++)
            send_pkt(SEQ_W'(s), {8{s[3:0]}}, 1'b1);
        // fill the whole window behind a gap, then close it: full drain
        for (int s = 12; s <= 18; s++)
            send_pkt(SEQ_W'(s), ~{8{s[3:0]}}, 1'b1);
        send_pkt(4'd15, 32'hFFFF_FFFF, 1'b0);
        send_pkt(4'd11, 32'hB0B0_B0B0, 1'b1);
        tx_base = 4'd3;
        drain_wait();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 53;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            good_sent = 0;
            while (good_sent < PHASE_ITEMS)
            begin
                if (phase == 0 && good_sent >= 40 && hold_requests == 0)
                    hold_requests++;
                send_burst();
            end
            drain_wait();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
